>>> rtl/core/scfl_pkg.sv
// Package for the size-class free-list allocator.
// Holds default parameters, request/command types, status codes and back-part states.
package scfl_pkg;

    localparam int HEAP_BYTES_DEF    = 65536;
    localparam int POINTER_BYTES_DEF = 8;
    localparam int NUM_CLASSES_DEF   = 32;
    localparam int ADDR_W            = 16;
    localparam int SIZE_W            = 17;
    localparam int CLASS_W           = 6;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_ZALLOC,
        CMD_ALLOC,
        CMD_FREE,
        CMD_CLEAR,
        CMD_FAIL
    } cmd_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [1:0]          status;
        logic [CLASS_W-1:0]  cls;
        logic [SIZE_W-1:0]   granted;
        logic [ADDR_W-1:0]   addr;
    } req_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_OUT
    } bk_state_t;

endpackage

>>> rtl/core/scfl_front.sv
// Front part: decodes a request and classifies its size into a size class.
// Depends on scfl_pkg.
module scfl_front #(
    parameter int HEAP_BYTES    = scfl_pkg::HEAP_BYTES_DEF,
    parameter int POINTER_BYTES = scfl_pkg::POINTER_BYTES_DEF,
    parameter int NUM_CLASSES   = scfl_pkg::NUM_CLASSES_DEF
) (
    input  logic [1:0]                      action,
    input  logic [scfl_pkg::SIZE_W-1:0]     size,
    input  logic [scfl_pkg::ADDR_W-1:0]     address,
    input  logic [scfl_pkg::ADDR_W-1:0]     heap_start,
    input  logic [scfl_pkg::SIZE_W-1:0]     eff_limit,
    output scfl_pkg::req_t                  req
);
    import scfl_pkg::*;

    localparam int CLS_AW = $clog2(NUM_CLASSES);

    logic [31:0]        cls_size [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] fits;
    logic [CLASS_W-1:0] cls;
    logic               found;

    // Class sizes are constants: even classes double, odd ones sit halfway.
    for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_cls
        localparam longint BASE = longint'(POINTER_BYTES) << (c / 2);
        localparam longint CS   = (c % 2 == 0) ? BASE : BASE + BASE / 2;
        assign cls_size[c] = (CS > longint'(HEAP_BYTES)) ? 32'hFFFF_FFFF : 32'(CS);
        assign fits[c] = (CS <= longint'(HEAP_BYTES)) && ({15'd0, size} <= 32'(CS));
    end

    always_comb
    begin
        found = 1'b0;
        cls   = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (fits[c]) begin
                found = 1'b1;
                cls   = CLASS_W'(c);
            end
        end
    end

    always_comb
    begin
        req.cmd     = CMD_NOP;
        req.status  = ST_OK;
        req.cls     = cls;
        req.granted = found ? SIZE_W'(cls_size[cls[CLS_AW-1:0]]) : {SIZE_W{1'b1}};
        req.addr    = address;
        unique case (action)
            ACT_ALLOC:
            begin
                if (size == '0) begin
                    req.cmd = CMD_ZALLOC;  req.status = ST_ZERO;  req.granted = '0;
                end else if (!found) begin
                    req.cmd = CMD_FAIL;    req.status = ST_OOM;
                end else begin
                    req.cmd = CMD_ALLOC;
                end
            end
            ACT_FREE:
            begin
                if (size == '0) begin
                    req.cmd = CMD_FAIL;    req.status = ST_ZERO;  req.granted = '0;
                end else if (!found || address < heap_start
                             || {1'b0, address} >= eff_limit) begin
                    req.cmd = CMD_FAIL;    req.status = ST_RANGE;
                end else begin
                    req.cmd = CMD_FREE;
                end
            end
            ACT_CLEAR:
            begin
                req.cmd = CMD_CLEAR;  req.granted = '0;
            end
            default:
            begin
                req.cmd = CMD_NOP;    req.granted = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/scfl_queue.sv
// Two-entry request queue between the front and back parts.
// Depends on scfl_pkg.
module scfl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  scfl_pkg::req_t  in_req,
    output logic            out_valid,
    input  logic            out_ready,
    output scfl_pkg::req_t  out_req
);
    import scfl_pkg::*;

    req_t       mem_reg [2];
    logic       wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

>>> rtl/core/scfl_back.sv
// Back part: class heads, top pointer and link store; executes requests.
// Depends on scfl_pkg.
module scfl_back #(
    parameter int HEAP_BYTES  = scfl_pkg::HEAP_BYTES_DEF,
    parameter int NUM_CLASSES = scfl_pkg::NUM_CLASSES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  scfl_pkg::req_t                  req,
    input  logic [scfl_pkg::ADDR_W-1:0]     heap_start,
    input  logic [scfl_pkg::SIZE_W-1:0]     eff_limit,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic [scfl_pkg::ADDR_W-1:0]     address_res,
    output logic [1:0]                      status,
    output logic [scfl_pkg::SIZE_W-1:0]     granted_size,
    output logic [scfl_pkg::SIZE_W-1:0]     heap_used
);
    import scfl_pkg::*;

    localparam int LINK_DEPTH = HEAP_BYTES / 4;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    localparam int CLS_AW     = $clog2(NUM_CLASSES);
    localparam logic [SIZE_W-1:0] EMPTY = SIZE_W'(HEAP_BYTES);

    logic [SIZE_W-1:0]  link_mem [LINK_DEPTH];
    logic [SIZE_W-1:0]  link_rd_reg;
    logic [SIZE_W-1:0]  head_reg [NUM_CLASSES];
    logic [SIZE_W-1:0]  top_reg, top_next;
    bk_state_t          state_reg, state_next;
    req_t               cur_reg;
    logic [ADDR_W-1:0]  ores_addr_reg, ores_addr_next;
    logic [1:0]         ost_reg, ost_next;
    logic [SIZE_W-1:0]  ogr_reg, ogr_next;
    logic               take, done_exec;
    logic [SIZE_W-1:0]  head_cur;
    logic [SIZE_W:0]    new_top;
    logic [LINK_AW-1:0] link_idx;
    logic               head_wr, link_wr;
    logic [SIZE_W-1:0]  head_wdata;

    assign head_cur  = head_reg[cur_reg.cls[CLS_AW-1:0]];
    assign new_top   = {1'b0, top_reg} + {1'b0, cur_reg.granted};
    assign req_ready = (state_reg == BK_IDLE);
    assign take      = req_valid && req_ready;
    assign res_valid = (state_reg == BK_OUT);
    assign address_res  = ores_addr_reg;
    assign status       = ost_reg;
    assign granted_size = ogr_reg;
    assign heap_used    = (top_reg >= {1'b0, heap_start})
                          ? top_reg - {1'b0, heap_start} : '0;

    always_comb
    begin
        unique case (state_reg)
            BK_IDLE: state_next = take ? BK_READ : BK_IDLE;
            BK_READ: state_next = BK_OUT;
            BK_OUT:  state_next = res_ready ? BK_IDLE : BK_OUT;
            default: state_next = BK_IDLE;
        endcase
    end

    assign done_exec = (state_reg == BK_READ);

    always_comb
    begin
        top_next       = top_reg;
        ores_addr_next = ores_addr_reg;
        ost_next       = ost_reg;
        ogr_next       = ogr_reg;
        head_wr        = 1'b0;
        link_wr        = 1'b0;
        head_wdata     = link_rd_reg;
        link_idx       = cur_reg.addr[LINK_AW+1:2];
        if (done_exec) begin
            ores_addr_next = '0;
            ost_next       = cur_reg.status;
            ogr_next       = cur_reg.granted;
            unique case (cur_reg.cmd)
                CMD_ZALLOC: ores_addr_next = top_reg[ADDR_W-1:0];
                CMD_ALLOC:
                begin
                    if (head_cur != EMPTY) begin
                        ores_addr_next = head_cur[ADDR_W-1:0];
                        head_wr        = 1'b1;
                        head_wdata     = link_rd_reg;
                    end else if (new_top > {1'b0, eff_limit}) begin
                        ost_next = ST_OOM;
                    end else begin
                        ores_addr_next = top_reg[ADDR_W-1:0];
                        top_next       = new_top[SIZE_W-1:0];
                    end
                end
                CMD_FREE:
                begin
                    link_wr    = 1'b1;
                    head_wr    = 1'b1;
                    head_wdata = {1'b0, cur_reg.addr};
                end
                CMD_CLEAR: top_next = {1'b0, heap_start};
                default: ;
            endcase
        end
    end

    // The link store is read at the class head of a request when the request is taken.
    always_ff @(posedge clk)
    begin
        if (take) begin
            cur_reg     <= req;
            link_rd_reg <= link_mem[head_reg[req.cls[CLS_AW-1:0]][LINK_AW+1:2]];
        end
        if (link_wr) begin
            link_mem[link_idx] <= head_cur;
        end
        ores_addr_reg <= ores_addr_next;
        ost_reg       <= ost_next;
        ogr_reg       <= ogr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= BK_IDLE;
            top_reg   <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                head_reg[i] <= EMPTY;
            end
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
            if (done_exec && cur_reg.cmd == CMD_CLEAR) begin
                for (int i = 0; i < NUM_CLASSES; i++) begin
                    head_reg[i] <= EMPTY;
                end
            end else if (head_wr) begin
                head_reg[cur_reg.cls[CLS_AW-1:0]] <= head_wdata;
            end
        end
    end

endmodule

>>> rtl/core/size_class_free_list_allocator.sv
// Size-class free-list allocator, top level: config registers, front, queue, back.
// The back part works one request at a time, through BK_IDLE, BK_READ and BK_OUT;
// the link-store read on taking a request comes before the head update.
// Reset empties all class lists, sets top to heap_start and clears the queue.
// Depends on scfl_pkg, scfl_front, scfl_queue and scfl_back.
module size_class_free_list_allocator #(
    parameter int HEAP_BYTES    = scfl_pkg::HEAP_BYTES_DEF,
    parameter int POINTER_BYTES = scfl_pkg::POINTER_BYTES_DEF,
    parameter int NUM_CLASSES   = scfl_pkg::NUM_CLASSES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // action[1:0], size[18:2], address[34:19]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,  // address_res, status, granted_size, heap_used
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [16:0]  cfg_data
);
    import scfl_pkg::*;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    logic [ADDR_W-1:0] start_reg;
    logic [SIZE_W-1:0] limit_reg, eff_limit;
    req_t              f_req, q_req;
    logic              q_valid, q_ready;
    logic [ADDR_W-1:0] address_res;
    logic [1:0]        status;
    logic [SIZE_W-1:0] granted_size, heap_used;

    assign eff_limit = ({15'd0, limit_reg} < 32'(HEAP_BYTES))
                       ? limit_reg : SIZE_W'(HEAP_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_reg <= '0;
            limit_reg <= 17'h10000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_START: start_reg <= cfg_data[ADDR_W-1:0];
                CFG_LIMIT: limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    scfl_front #(
        .HEAP_BYTES(HEAP_BYTES), .POINTER_BYTES(POINTER_BYTES),
        .NUM_CLASSES(NUM_CLASSES)
    ) u_front (
        .action(s_axis_tdata[1:0]), .size(s_axis_tdata[18:2]),
        .address(s_axis_tdata[34:19]), .heap_start(start_reg),
        .eff_limit(eff_limit), .req(f_req)
    );

    scfl_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(f_req),
        .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
    );

    scfl_back #(.HEAP_BYTES(HEAP_BYTES), .NUM_CLASSES(NUM_CLASSES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .heap_start(start_reg), .eff_limit(eff_limit),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .address_res(address_res), .status(status),
        .granted_size(granted_size), .heap_used(heap_used)
    );

    assign m_axis_tdata = {4'd0, heap_used, granted_size, status, address_res};

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for size_class_free_list_allocator.
// Drives allocate, free, clear and unused requests over the stream ports, predicts each
// result with an internal heap model, and needs scfl_pkg plus the allocator RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import scfl_pkg::*;

    localparam logic [1:0] ACT_NOP        = 2'd3;
    localparam logic       REG_HEAP_START = 1'b0;
    localparam logic       REG_HEAP_LIMIT = 1'b1;
    localparam int         EMPTY_HEAD     = 65536;
    localparam int         IDLE_LIMIT     = 5000;

    typedef struct {
        logic [15:0] addr;
        logic [1:0]  status;
        logic [16:0] granted;
        logic [16:0] used;
    } alloc_result_t;

    typedef struct {
        logic [15:0] addr;
        logic [16:0] size;
    } live_block_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [16:0] cfg_data;

    size_class_free_list_allocator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Heap model state.
    logic [15:0]   heap_start;
    logic [16:0]   heap_limit;
    logic [16:0]   top_ptr;
    logic [16:0]   class_head [32];
    logic [16:0]   next_link [16384];
    alloc_result_t pending_results [$];
    live_block_t   live_blocks [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int requests_sent  = 0;
    int ok_allocs      = 0;
    int idle_cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int class_of(input logic [16:0] req, output logic [16:0] granted);
        longint cs;
        longint half;
        cs = 8;
        half = 0;
        for (int c = 0; c < 32; c++)
        begin
            if ((c & 1) == 0)
                half = cs >> 1;
            if (req <= cs)
            begin
                if (cs > 65536)
                    break;
                granted = cs[16:0];
                return c;
            end
            cs += half;
        end
        granted = 17'h1FFFF;
        return -1;
    endfunction

    function automatic alloc_result_t predict_heap(input logic [1:0] act, input logic [16:0] size,
                                                   input logic [15:0] addr);
        alloc_result_t r;
        int            c;
        logic [16:0]   lim;
        logic [17:0]   nt;
        r = '{addr: 16'd0, status: ST_OK, granted: 17'd0, used: 17'd0};
        lim = (heap_limit < 17'd65536) ? heap_limit : 17'd65536;
        if (act == ACT_ALLOC)
        begin
            if (size == 0)
            begin
                r.addr = top_ptr[15:0];
                r.status = ST_ZERO;
            end
            else
            begin
                c = class_of(size, r.granted);
                if (c < 0)
                    r.status = ST_OOM;
                else if (class_head[c] != EMPTY_HEAD)
                begin
                    r.addr = class_head[c][15:0];
                    class_head[c] = next_link[class_head[c][15:2]];
                end
                else
                begin
                    nt = top_ptr + r.granted;
                    if (nt > lim)
                        r.status = ST_OOM;
                    else
                    begin
                        r.addr = top_ptr[15:0];
                        top_ptr = nt[16:0];
                    end
                end
            end
        end
        else if (act == ACT_FREE)
        begin
            if (size == 0)
                r.status = ST_ZERO;
            else
            begin
                c = class_of(size, r.granted);
                if (c < 0 || addr < heap_start || addr >= lim)
                    r.status = ST_RANGE;
                else
                begin
                    next_link[addr[15:2]] = class_head[c];
                    class_head[c] = {1'b0, addr};
                end
            end
        end
        else if (act == ACT_CLEAR)
        begin
            top_ptr = {1'b0, heap_start};
            for (int i = 0; i < 32; i++)
                class_head[i] = 17'(EMPTY_HEAD);
        end
        r.used = (top_ptr >= heap_start) ? top_ptr - heap_start : 17'd0;
        return r;
    endfunction

    task automatic send_request(input logic [1:0] act, input logic [16:0] size,
                                input logic [15:0] addr);
        alloc_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, addr, size, act};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = predict_heap(act, size, addr);
        pending_results.push_back(r);
        requests_sent++;
        if (act == ACT_ALLOC && r.status == ST_OK)
        begin
            ok_allocs++;
            live_blocks.push_back('{addr: r.addr, size: size});
        end
        if (act == ACT_CLEAR)
            live_blocks.delete();
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == REG_HEAP_START)
            heap_start = value[15:0];
        else
            heap_limit = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_heap(input logic [15:0] start, input logic [16:0] limit);
        drain_results();
        write_reg(REG_HEAP_START, {1'b0, start});
        write_reg(REG_HEAP_LIMIT, limit);
        send_request(ACT_CLEAR, 17'd0, 16'd0);
    endtask

    task automatic free_live_block();
        int          k;
        live_block_t b;
        k = $urandom_range(live_blocks.size() - 1);
        b = live_blocks[k];
        live_blocks.delete(k);
        send_request(ACT_FREE, b.size, b.addr);
    endtask

    function automatic logic [16:0] pick_size();
        int p;
        p = $urandom_range(99);
        if (p < 80)
            return 17'($urandom_range(1, 200));
        else if (p < 95)
            return 17'($urandom_range(1, 4096));
        return 17'($urandom_range(0, 17'h1FFFF));
    endfunction

    task automatic test_directed();
        set_heap(16'h0100, 17'h00400);
        send_request(ACT_ALLOC, 17'd0, 16'd0);
        send_request(ACT_ALLOC, 17'd1, 16'd0);
        send_request(ACT_ALLOC, 17'd9, 16'd0);
        send_request(ACT_ALLOC, 17'd13, 16'd0);
        send_request(ACT_FREE, 17'd8, 16'h0100);
        send_request(ACT_FREE, 17'd12, 16'h0108);
        send_request(ACT_ALLOC, 17'd5, 16'd0);
        send_request(ACT_ALLOC, 17'd10, 16'd0);
        send_request(ACT_FREE, 17'd0, 16'h0100);
        send_request(ACT_FREE, 17'd8, 16'h00FF);
        send_request(ACT_FREE, 17'd8, 16'h0400);
        send_request(ACT_FREE, 17'd8, 16'hFFFF);
        send_request(ACT_FREE, 17'h1FFFF, 16'h0200);
        send_request(ACT_ALLOC, 17'd65536, 16'd0);
        send_request(ACT_ALLOC, 17'd65537, 16'd0);
        send_request(ACT_ALLOC, 17'h1FFFF, 16'd0);
        send_request(ACT_ALLOC, 17'd700, 16'd0);
        send_request(ACT_ALLOC, 17'd700, 16'd0);
        send_request(ACT_NOP, 17'h1FFFF, 16'hFFFF);
        send_request(ACT_CLEAR, 17'd0, 16'd0);
        set_heap(16'h0000, 17'h10000);
        send_request(ACT_ALLOC, 17'd65536, 16'd0);
        send_request(ACT_ALLOC, 17'd65536, 16'd0);
        send_request(ACT_ALLOC, 17'd0, 16'd0);
        send_request(ACT_ALLOC, 17'd1, 16'd0);
    endtask

    task automatic test_random(input int count);
        int p;
        for (int n = 0; n < count; n++)
        begin
            p = $urandom_range(99);
            if (p < 45)
                send_request(ACT_ALLOC, pick_size(), 16'd0);
            else if (p < 75 && live_blocks.size() > 0)
                free_live_block();
            else if (p < 88)
                send_request(ACT_FREE, pick_size(), 16'($urandom_range(0, 16'hFFFF)));
            else if (p < 92)
                send_request(ACT_CLEAR, pick_size(), 16'($urandom_range(0, 16'hFFFF)));
            else if (p < 95)
                send_request(ACT_NOP, pick_size(), 16'($urandom_range(0, 16'hFFFF)));
            else
                send_request(2'($urandom_range(0, 1)), 17'd0,
                             16'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    task automatic test_phases();
        logic [15:0] starts [5] = '{16'h0000, 16'h0200, 16'hFFFF, 16'h1000, 16'h0000};
        logic [16:0] limits [5] = '{17'h10000, 17'h01000, 17'h10000, 17'h00000, 17'h00800};
        int          stall [4]  = '{0, 0, 63, 11};
        int          gap [4]    = '{0, 63, 0, 11};
        for (int i = 0; i < 8; i++)
        begin
            set_heap(starts[i % 5], limits[i % 5]);
            send_idle_pct = gap[i % 4];
            recv_stall_pct = stall[i % 4];
            test_random(60);
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[15:0] !== want.addr || m_axis_tdata[17:16] !== want.status
                    || m_axis_tdata[34:18] !== want.granted
                    || m_axis_tdata[51:35] !== want.used)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp addr %h st %0d size %0d used %0d, got %h %0d %0d %0d",
                                 want.addr, want.status, want.granted, want.used,
                                 m_axis_tdata[15:0], m_axis_tdata[17:16], m_axis_tdata[34:18],
                                 m_axis_tdata[51:35]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        heap_start = 16'd0;
        heap_limit = 17'h10000;
        top_ptr = 17'd0;
        for (int i = 0; i < 32; i++)
            class_head[i] = 17'(EMPTY_HEAD);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_phases();
        drain_results();
        repeat (10) @(negedge clk);
        $display("Covered %0d requests (%0d successful allocations) and %0d results",
                 requests_sent, ok_allocs, results_seen);
        $display("over five heap windows and four idle patterns; %0d mismatches.", mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/scfl_pkg.sv
rtl/core/scfl_front.sv
rtl/core/scfl_queue.sv
rtl/core/scfl_back.sv
rtl/core/size_class_free_list_allocator.sv
verif/tb_top.sv
